[hw/rtl/srf_pkg.sv]
// Shared types and constants for the symmetric row FIR with replicate border.
// No dependencies; imported by every module of the block.
`default_nettype none

package srf_pkg;

  // Pixel and arithmetic widths
  localparam int CH_W    = 8;
  localparam int PIX_W   = 3 * CH_W;
  localparam int COEF_W  = 16;
  localparam int NCOEF   = 16;
  localparam int TERM_W  = CH_W + 1;
  localparam int PROD_W  = TERM_W + COEF_W;
  localparam int FRAC    = 15;
  localparam int ROUND   = 1 << (FRAC - 1);
  localparam int CH_MAX  = (1 << CH_W) - 1;

  // Configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 64;
  localparam int TAPS_W    = 5;
  localparam logic [CFG_IDX_W-1:0] CFG_TAPS  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COEF0 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COEF1 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_COEF2 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_COEF3 = 3'd4;

  // Result buffer
  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_AW    = 3;
  localparam int CRED_W     = $clog2(FIFO_DEPTH + 1);

  typedef logic [PIX_W-1:0] pix_t;

  // Window cell control
  typedef struct packed {
    logic load;
    logic shift;
  } cell_ctl_t;

  // One buffered result word
  typedef struct packed {
    logic            last;
    logic [CH_W-1:0] blue;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] red;
  } res_word_t;

  function automatic logic [CH_W-1:0] chan_of(input pix_t pix, input int c);
    return pix[CH_W*c +: CH_W];
  endfunction

endpackage

`default_nettype wire

[hw/rtl/srf_cell.sv]
// One window cell: holds a packed RGB pixel and hands it to its neighbor.
// Depends on srf_pkg.
`default_nettype none

module srf_cell import srf_pkg::*; (
  input  logic      clk,
  input  cell_ctl_t ctl,
  input  pix_t      fill,
  input  pix_t      prev,
  output pix_t      q
);

  // Load the row's first pixel everywhere, otherwise take the neighbor's word
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      q <= fill;
    end else if (ctl.shift) begin
      q <= prev;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/srf_chan.sv]
// Multiply-accumulate pipeline for one color channel: products, group sums,
// then final sum with round half up and saturation. Depends on srf_pkg.
`default_nettype none

module srf_chan import srf_pkg::*; #(
  parameter int NTERM = 16
) (
  input  logic              clk,
  input  logic [TERM_W-1:0] term [NTERM],
  input  logic [COEF_W-1:0] coef [NTERM],
  output logic [CH_W-1:0]   res
);

  localparam int NG = (NTERM + 3) / 4;
  localparam int GW = PROD_W + 2;
  localparam int SW = GW + 3;

  logic [PROD_W-1:0] prod [NTERM];
  logic [GW-1:0]     gsum_next [NG];
  logic [GW-1:0]     gsum [NG];
  logic [SW-1:0]     total;
  logic [SW-FRAC-1:0] scaled;

  // Register one product per tap
  always_ff @(posedge clk) begin
    for (int k = 0; k < NTERM; k++) begin
      prod[k] <= PROD_W'(term[k]) * PROD_W'(coef[k]);
    end
  end

  // Add products in groups of four
  always_comb begin
    for (int g = 0; g < NG; g++) begin
      gsum_next[g] = '0;
      for (int j = 0; j < 4; j++) begin
        if (4 * g + j < NTERM) begin
          gsum_next[g] = gsum_next[g] + GW'(prod[4 * g + j]);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    gsum <= gsum_next;
  end

  // Final sum, round half up, saturate
  always_comb begin
    total = SW'(ROUND);
    for (int g = 0; g < NG; g++) begin
      total = total + SW'(gsum[g]);
    end
    scaled = total[SW-1:FRAC];
    if (scaled > (SW-FRAC)'(CH_MAX)) begin
      res = CH_W'(CH_MAX);
    end else begin
      res = scaled[CH_W-1:0];
    end
  end

endmodule

`default_nettype wire

[hw/rtl/symmetric_row_fir_replicate_border.sv]
// Top level of the symmetric row FIR with replicate border: window chain,
// step control, tap selection, channel pipelines and result buffer.
// Depends on srf_pkg, srf_cell and srf_chan.
//
//  port group  | handshake            | payload
//  ------------+----------------------+-------------------------------------
//  pixel in    | pix_valid, pix_stall | red_in, green_in, blue_in, row_end_in
//  result out  | res_valid, res_stall | red_out, green_out, blue_out,
//              |                      | row_end_out
//  config      | cfg_valid, cfg_ready | cfg_index, cfg_data
//
// One pixel is taken per cycle while pix_stall is low. A pixel marked row end
// starts R flush steps (R = radius) in which the window shifts the last pixel and pix_stall is high.
// A result passes the term, product and group-sum registers, then enters the 8-word output buffer.
// A stalled result side fills that buffer, then pix_stall holds the input.
// Reset is synchronous; cfg_ready is always high.
`default_nettype none

module symmetric_row_fir_replicate_border import srf_pkg::*; #(
  parameter int MAX_TAPS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  // pixel channel
  input  logic                 pix_valid,
  output logic                 pix_stall,
  input  logic [CH_W-1:0]      red_in,
  input  logic [CH_W-1:0]      green_in,
  input  logic [CH_W-1:0]      blue_in,
  input  logic                 row_end_in,
  // result channel
  output logic                 res_valid,
  input  logic                 res_stall,
  output logic [CH_W-1:0]      red_out,
  output logic [CH_W-1:0]      green_out,
  output logic [CH_W-1:0]      blue_out,
  output logic                 row_end_out,
  // configuration channel
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_data
);

  localparam int WIN_DEPTH = 2 * MAX_TAPS - 1;
  localparam int NTERM     = (MAX_TAPS < NCOEF) ? MAX_TAPS : NCOEF;
  localparam int RW        = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
  localparam int FW        = $clog2(MAX_TAPS + 1);

  // Configuration registers
  logic [TAPS_W-1:0]    taps_in_use;
  logic [CFG_DAT_W-1:0] coef_word [4];

  // Control state
  logic              row_starting;
  logic [FW-1:0]     fill;
  logic              flushing;
  logic [RW-1:0]     flush_cnt;
  logic [CRED_W-1:0] credit_used;
  logic [3:0]        vld;
  logic [3:0]        last;

  // Window and datapath
  pix_t              win [WIN_DEPTH];
  pix_t              pix;
  pix_t              shift_src;
  cell_ctl_t         cell_ctl;
  logic [TERM_W-1:0] term_sel [3][NTERM];
  logic [TERM_W-1:0] term_q [3][NTERM];
  logic [COEF_W-1:0] coef_sel [NTERM];
  logic [CH_W-1:0]   chan_res [3];

  // Result buffer
  res_word_t         fifo_mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr;
  logic [FIFO_AW-1:0] rd_ptr;
  logic [CRED_W-1:0] fifo_cnt;
  res_word_t         rd_word;

  // Step control signals
  logic [5:0]    taps_ext;
  logic [5:0]    taps_clamp;
  logic [RW-1:0] rad;
  logic [FW-1:0] rad_p1;
  logic          credit_ok;
  logic          pix_acc;
  logic          res_acc;
  logic          cfg_acc;
  logic          step;
  logic          load;
  logic          flush_step;
  logic          final_step;
  logic          emit;
  logic [FW-1:0] fill_inc;
  logic [FW-1:0] fill_step;

  // Configuration writes
  assign cfg_ready = 1'b1;
  assign cfg_acc   = cfg_valid & cfg_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      taps_in_use  <= TAPS_W'(1);
      coef_word[0] <= CFG_DAT_W'(32768);
      coef_word[1] <= '0;
      coef_word[2] <= '0;
      coef_word[3] <= '0;
    end else if (cfg_acc) begin
      case (cfg_index)
        CFG_TAPS:  taps_in_use  <= cfg_data[TAPS_W-1:0];
        CFG_COEF0: coef_word[0] <= cfg_data;
        CFG_COEF1: coef_word[1] <= cfg_data;
        CFG_COEF2: coef_word[2] <= cfg_data;
        CFG_COEF3: coef_word[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  // Clamp tap count and derive radius
  assign taps_ext = {1'b0, taps_in_use};

  always_comb begin
    if (taps_ext == 6'd0) begin
      taps_clamp = 6'd1;
    end else if (taps_ext > 6'(MAX_TAPS)) begin
      taps_clamp = 6'(MAX_TAPS);
    end else begin
      taps_clamp = taps_ext;
    end
  end

  assign rad    = RW'(taps_clamp - 6'd1);
  assign rad_p1 = FW'(taps_clamp);

  // Unpack coefficient fields
  always_comb begin
    for (int i = 0; i < NTERM; i++) begin
      coef_sel[i] = coef_word[i >> 2][COEF_W * (i & 3) +: COEF_W];
    end
  end

  // Step decision: a new pixel or one flush shift
  assign credit_ok  = credit_used < CRED_W'(FIFO_DEPTH);
  assign pix_stall  = flushing | ~credit_ok;
  assign pix_acc    = pix_valid & ~pix_stall;
  assign flush_step = flushing & credit_ok;
  assign step       = pix_acc | flush_step;
  assign load       = pix_acc & row_starting;
  assign fill_inc   = (fill < rad_p1) ? fill + FW'(1) : fill;
  assign fill_step  = load ? FW'(1) : fill_inc;
  assign emit       = step & (fill_step >= rad_p1);
  assign final_step = (pix_acc & row_end_in & (rad == '0)) |
                      (flush_step & (flush_cnt == RW'(1)));

  assign pix       = {blue_in, green_in, red_in};
  assign shift_src = flushing ? win[0] : pix;
  assign cell_ctl  = '{load: load, shift: step & ~load};

  // Row control state
  always_ff @(posedge clk) begin
    if (rst) begin
      row_starting <= 1'b1;
      fill         <= '0;
      flushing     <= 1'b0;
      flush_cnt    <= '0;
    end else begin
      if (step) begin
        row_starting <= final_step;
        fill         <= final_step ? '0 : fill_step;
      end
      if (pix_acc && row_end_in && (rad != '0)) begin
        flushing  <= 1'b1;
        flush_cnt <= rad;
      end else if (flush_step) begin
        flush_cnt <= flush_cnt - RW'(1);
        if (flush_cnt == RW'(1)) begin
          flushing <= 1'b0;
        end
      end
    end
  end

  // Window chain, newest pixel in cell 0
  for (genvar k = 0; k < WIN_DEPTH; k++) begin : g_cell
    srf_cell u_cell (
      .clk  (clk),
      .ctl  (cell_ctl),
      .fill (pix),
      .prev ((k == 0) ? shift_src : win[(k == 0) ? 0 : k - 1]),
      .q    (win[k])
    );
  end

  // Select centre and mirrored pairs around the current radius
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      for (int i = 0; i < NTERM; i++) begin
        term_sel[c][i] = '0;
        for (int k = i; k < MAX_TAPS; k++) begin
          if (rad == RW'(k)) begin
            if (i == 0) begin
              term_sel[c][i] = {1'b0, chan_of(win[k], c)};
            end else begin
              term_sel[c][i] = TERM_W'(chan_of(win[k - i], c)) +
                               TERM_W'(chan_of(win[k + i], c));
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    term_q <= term_sel;
  end

  // Per-channel multiply-accumulate
  for (genvar c = 0; c < 3; c++) begin : g_chan
    srf_chan #(.NTERM(NTERM)) u_chan (
      .clk  (clk),
      .term (term_q[c]),
      .coef (coef_sel),
      .res  (chan_res[c])
    );
  end

  // Advance valid and last flags alongside the datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[2:0], emit};
    end
  end

  always_ff @(posedge clk) begin
    last <= {last[2:0], final_step};
  end

  // Result buffer; credits cover every word in flight
  assign res_acc = res_valid & ~res_stall;

  always_ff @(posedge clk) begin
    if (vld[3]) begin
      fifo_mem[wr_ptr] <= '{last: last[3], blue: chan_res[2],
                            green: chan_res[1], red: chan_res[0]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr      <= '0;
      rd_ptr      <= '0;
      fifo_cnt    <= '0;
      credit_used <= '0;
    end else begin
      if (vld[3]) begin
        wr_ptr <= wr_ptr + FIFO_AW'(1);
      end
      if (res_acc) begin
        rd_ptr <= rd_ptr + FIFO_AW'(1);
      end
      fifo_cnt    <= fifo_cnt + CRED_W'(vld[3]) - CRED_W'(res_acc);
      credit_used <= credit_used + CRED_W'(emit) - CRED_W'(res_acc);
    end
  end

  assign rd_word     = fifo_mem[rd_ptr];
  assign res_valid   = fifo_cnt != '0;
  assign red_out     = rd_word.red;
  assign green_out   = rd_word.green;
  assign blue_out    = rd_word.blue;
  assign row_end_out = rd_word.last;

  // Credits equal buffered words plus words in the pipeline
  a_credit_match: assert property (@(posedge clk) disable iff (rst)
    credit_used == fifo_cnt + CRED_W'($countones(vld)))
    else $error("credit count out of step with buffered results");

  // A flush never runs while a row is waiting to start
  a_flush_row: assert property (@(posedge clk) disable iff (rst)
    flushing |-> !row_starting)
    else $error("flush active at row start");

  // The final step of a row rearms the row start
  a_final_rearm: assert property (@(posedge clk) disable iff (rst)
    step && final_step |=> row_starting && (fill == '0) && !flushing)
    else $error("row not rearmed after final step");

  // Buffer never overflows
  a_fifo_bound: assert property (@(posedge clk) disable iff (rst)
    fifo_cnt <= CRED_W'(FIFO_DEPTH))
    else $error("result buffer overflow");

endmodule

`default_nettype wire
